FILE: rtl/core/inmr_pkg.sv
// Shared types and constants for the in-place neighbor mean raster unit.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package inmr_pkg;

   // Default sizes of the line memories and of the internal pixel path.
   localparam int MAX_COLS_DEFAULT   = 1024;
   localparam int PIXEL_BITS_DEFAULT = 8;

   // Frame dimension registers and their legal range.
   localparam int DIM_BITS = 11;
   localparam int DIM_MIN  = 2;
   localparam int DIM_MAX  = 1024;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_ROWS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_COLS = 2'd1;

   // Widths of the words on the two channels.
   localparam int PORT_PIXEL_BITS = 8;
   localparam int OUT_POS_BITS    = 10;

   // Input word operations.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic                       op;
      logic [PORT_PIXEL_BITS-1:0] pixel;
   } req_word_type;

   typedef struct packed {
      logic [PORT_PIXEL_BITS-1:0] mean_value;
      logic [OUT_POS_BITS-1:0]    out_row;
      logic [OUT_POS_BITS-1:0]    out_col;
      logic                       last_of_frame;
   } rsp_word_type;

endpackage

FILE: rtl/core/inplace_neighbor_mean_raster_unit.sv
// Results: the word at position p + cols + 1 (pixel or flush) releases the result for
// pixel p via the compute stage and output register; cols + 1 flush words drain a frame.
// Throughput: one word per cycle unless rsp stalls; set by the left-neighbor feedback loop
// (neighbor adder, reciprocal multiplier, mean register), one read port per line memory.
// Reset: dimensions return to 2 x 2 and the frame restarts; the line memories are not
// cleared; every read that feeds a result hits an entry written earlier in that frame.
module inplace_neighbor_mean_raster_unit
   import inmr_pkg::*;
#(
   parameter int MAX_COLS   = MAX_COLS_DEFAULT,
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word
);

   // Column address, column register and arithmetic widths.
   localparam int COL_BITS    = $clog2(MAX_COLS);
   localparam int COLS_BITS   = $clog2(MAX_COLS + 1);
   localparam int COLS_HI     = (MAX_COLS < DIM_MAX) ? MAX_COLS : DIM_MAX;
   localparam int SUM_BITS    = PIXEL_BITS + 3;
   localparam int RECIP_SHIFT = SUM_BITS + 3;
   localparam int PROD_BITS   = SUM_BITS + RECIP_SHIFT;
   localparam logic [RECIP_SHIFT-1:0] RECIP_5 = RECIP_SHIFT'((1 << RECIP_SHIFT) / 5 + 1);
   localparam logic [RECIP_SHIFT-1:0] RECIP_3 = RECIP_SHIFT'((1 << RECIP_SHIFT) / 3 + 1);

   // Configuration registers.
   logic [DIM_BITS-1:0]  rows_ff, rows_in;
   logic [COLS_BITS-1:0] cols_ff, cols_in;

   // Input position and result pointer.
   logic [DIM_BITS-1:0]  in_row_ff, in_row_in;
   logic [COL_BITS-1:0]  in_col_ff, in_col_in;
   logic [DIM_BITS-1:0]  res_row_ff, res_row_in;
   logic [COL_BITS-1:0]  res_col_ff, res_col_in;

   // Line memories and their registered read data.
   logic [PIXEL_BITS-1:0] orig_mem [MAX_COLS];
   logic [PIXEL_BITS-1:0] upd_mem  [MAX_COLS];
   logic [PIXEL_BITS-1:0] orig_rd_ff;
   logic [PIXEL_BITS-1:0] upd_rd_ff;
   logic                  fwd_ff;

   // Recent original pixels: the lower-right, lower and lower-left neighbors.
   logic [PIXEL_BITS-1:0] pix0_ff, pix1_ff, pix2_ff;

   // Compute stage.
   logic                  b_valid_ff, b_valid_in;
   logic [DIM_BITS-1:0]   b_row_ff;
   logic [COL_BITS-1:0]   b_col_ff;
   logic                  b_up_ff, b_down_ff, b_left_ff, b_right_ff, b_last_ff;
   logic [PIXEL_BITS-1:0] ub_ff, uc_ff, mean_ff;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff;

   // Combinational signals.
   logic                  accept, in_frame, is_flush, counted, has_result, in_col_wrap;
   logic                  res_up, res_down, res_left, res_right, res_last;
   logic [COL_BITS-1:0]   upd_ra;
   logic                  b_adv, b_fire;
   logic [DIM_BITS-1:0]   dim_clamped;
   logic [PIXEL_BITS-1:0] pix_in, ua, mean_calc;
   logic [SUM_BITS-1:0]   sum;
   logic                  corner, interior;
   logic [RECIP_SHIFT-1:0] recip;
   logic [PROD_BITS-1:0]  prod;

   // Handshake of the compute stage and the input side.
   assign b_adv     = !rsp_valid_ff || !rsp_stall;
   assign b_fire    = b_valid_ff && b_adv;
   assign req_stall = b_valid_ff && !b_adv;
   assign accept    = req_valid && !req_stall;

   // Classify the incoming word and the result it would produce.
   always_comb begin
      in_frame    = in_row_ff < rows_ff;
      is_flush    = req_word.op == OP_FLUSH;
      counted     = accept && !(in_frame && is_flush);
      pix_in      = PIXEL_BITS'(req_word.pixel);
      has_result  = counted && ((in_row_ff > DIM_BITS'(1)) ||
                                (in_row_ff == DIM_BITS'(1) && in_col_ff != '0));
      in_col_wrap = (COLS_BITS'(in_col_ff) + COLS_BITS'(1)) == cols_ff;
      res_up      = res_row_ff != '0;
      res_down    = (res_row_ff + DIM_BITS'(1)) < rows_ff;
      res_left    = res_col_ff != '0;
      res_right   = (COLS_BITS'(res_col_ff) + COLS_BITS'(1)) != cols_ff;
      res_last    = !res_down && !res_right;
      // At a row end the next row's first upper value is fetched instead.
      upd_ra      = res_right ? (res_col_ff + COL_BITS'(1)) : '0;
   end

   // Configuration values clamped to the legal dimension range.
   always_comb begin
      if (csr_wdata < DIM_BITS'(DIM_MIN)) begin
         dim_clamped = DIM_BITS'(DIM_MIN);
      end else if (csr_wdata > DIM_BITS'(DIM_MAX)) begin
         dim_clamped = DIM_BITS'(DIM_MAX);
      end else begin
         dim_clamped = csr_wdata;
      end
   end

   // Next values of the configuration and the position counters.
   always_comb begin
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      res_row_in = res_row_ff;
      res_col_in = res_col_ff;

      if (counted) begin
         if (in_col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + DIM_BITS'(1);
         end else begin
            in_col_in = in_col_ff + COL_BITS'(1);
         end
      end

      if (has_result) begin
         if (res_last) begin
            in_row_in  = '0;
            in_col_in  = '0;
            res_row_in = '0;
            res_col_in = '0;
         end else if (!res_right) begin
            res_col_in = '0;
            res_row_in = res_row_ff + DIM_BITS'(1);
         end else begin
            res_col_in = res_col_ff + COL_BITS'(1);
         end
      end

      // A write to a decoded register also restarts the frame.
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_ROWS: begin
               rows_in    = dim_clamped;
               in_row_in  = '0;
               in_col_in  = '0;
               res_row_in = '0;
               res_col_in = '0;
            end
            CSR_FRAME_COLS: begin
               cols_in    = (dim_clamped > DIM_BITS'(COLS_HI)) ? COLS_BITS'(COLS_HI)
                                                                : COLS_BITS'(dim_clamped);
               in_row_in  = '0;
               in_col_in  = '0;
               res_row_in = '0;
               res_col_in = '0;
            end
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   // Compute stage and output register occupancy.
   always_comb begin
      b_valid_in = b_valid_ff;
      if (b_fire) begin
         b_valid_in = 1'b0;
      end
      if (has_result) begin
         b_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= DIM_BITS'(DIM_MIN);
         cols_ff      <= COLS_BITS'(DIM_MIN);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         res_row_ff   <= '0;
         res_col_ff   <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         res_row_ff   <= res_row_in;
         res_col_ff   <= res_col_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Original line memory: written by frame pixels, read one row back at the same column.
   always_ff @(posedge clock) begin
      if (accept && in_frame && !is_flush) begin
         orig_mem[in_col_ff] <= pix_in;
      end
      if (accept) begin
         orig_rd_ff <= orig_mem[in_col_ff];
      end
   end

   // Updated line memory: written by each result, read for the upper-right neighbor.
   always_ff @(posedge clock) begin
      if (b_fire) begin
         upd_mem[b_col_ff] <= mean_calc;
      end
      if (accept) begin
         upd_rd_ff <= upd_mem[upd_ra];
      end
   end

   // Load the compute stage; a read of the entry being written takes the new mean.
   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_ff <= b_fire && (b_col_ff == upd_ra);
      end
      if (counted) begin
         pix0_ff <= pix_in;
         pix1_ff <= pix0_ff;
         pix2_ff <= pix1_ff;
      end
      if (has_result) begin
         b_row_ff   <= res_row_ff;
         b_col_ff   <= res_col_ff;
         b_up_ff    <= res_up;
         b_down_ff  <= res_down;
         b_left_ff  <= res_left;
         b_right_ff <= res_right;
         b_last_ff  <= res_last;
      end
   end

   // Neighbor sum over the pixels that exist in the frame.
   always_comb begin
      ua  = fwd_ff ? mean_ff : upd_rd_ff;
      sum = ((b_up_ff && b_left_ff)    ? SUM_BITS'(uc_ff)      : '0)
          + (b_up_ff                   ? SUM_BITS'(ub_ff)      : '0)
          + ((b_up_ff && b_right_ff)   ? SUM_BITS'(ua)         : '0)
          + (b_left_ff                 ? SUM_BITS'(mean_ff)    : '0)
          + (b_right_ff                ? SUM_BITS'(orig_rd_ff) : '0)
          + ((b_down_ff && b_left_ff)  ? SUM_BITS'(pix2_ff)    : '0)
          + (b_down_ff                 ? SUM_BITS'(pix1_ff)    : '0)
          + ((b_down_ff && b_right_ff) ? SUM_BITS'(pix0_ff)    : '0);
   end

   // Mean: a shift for eight neighbors, a reciprocal multiply for five or three.
   always_comb begin
      interior  = b_up_ff && b_down_ff && b_left_ff && b_right_ff;
      corner    = (!b_up_ff || !b_down_ff) && (!b_left_ff || !b_right_ff);
      recip     = corner ? RECIP_3 : RECIP_5;
      prod      = PROD_BITS'(sum) * PROD_BITS'(recip);
      mean_calc = interior ? PIXEL_BITS'(sum >> 3) : PIXEL_BITS'(prod >> RECIP_SHIFT);
   end

   // Upper-row window, left-neighbor register and output word.
   always_ff @(posedge clock) begin
      if (b_fire) begin
         ub_ff   <= ua;
         uc_ff   <= ub_ff;
         mean_ff <= mean_calc;
         rsp_word_ff.mean_value    <= PORT_PIXEL_BITS'(mean_calc);
         rsp_word_ff.out_row       <= OUT_POS_BITS'(b_row_ff);
         rsp_word_ff.out_col       <= OUT_POS_BITS'(b_col_ff);
         rsp_word_ff.last_of_frame <= b_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/core/inmr_checker.sv
// Port-level checker for the in-place neighbor mean raster unit, with its bind.
// Depends on inmr_pkg for the result word type.
module inmr_checker
   import inmr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // Reset leaves no result pending and the input side open.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending or input stalled after reset");

   // The input side stalls only while a finished result is held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // A new result always traces back to a word accepted earlier.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result word without an accepted input word");

   // A blocked result word holds.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("blocked result word changed");

endmodule

bind inplace_neighbor_mean_raster_unit inmr_checker u_inmr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

FILE: tb/tb_top.sv
// Testbench for the in-place neighbor mean raster unit: random and directed pixel words,
// frame settings, and a cycle-free predictor of each mean result checked word by word.
// Depends on inmr_pkg and inplace_neighbor_mean_raster_unit only.
`timescale 1ns / 1ps

module tb_top
   import inmr_pkg::*;
();

   localparam int WIN_DEPTH = MAX_COLS_DEFAULT + 1;
   localparam int SETTLE_CYCLES = 4;

   // Register indexes that the block does not decode.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // Stimulus and bookkeeping.
   req_word_type outgoing_words[$];
   rsp_word_type expected_means[$];
   logic req_taken = 1'b0;
   logic hold = 1'b0;
   int idle_pct = 28;
   int error_count = 0;

   // Predictor state: dimensions, line windows and the raster position.
   int unsigned dim_rows = 2;
   int unsigned dim_cols = 2;
   logic [7:0] orig_line[WIN_DEPTH] = '{default: 8'h00};
   logic [7:0] mean_line[WIN_DEPTH] = '{default: 8'h00};
   int unsigned taken_count = 0;
   int unsigned next_row = 0;
   int unsigned next_col = 0;

   inplace_neighbor_mean_raster_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

   always #1 clock = ~clock;

   // The run ends here if the block stops making progress.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic void restart_frame();
      taken_count = 0;
      next_row = 0;
      next_col = 0;
   endfunction

   // Mirror of a register write: values are clamped and a decoded write restarts the frame.
   function automatic void apply_csr(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CSR_DATA_BITS-1:0] data);
      int unsigned v;
      v = 32'(data);
      if (v < DIM_MIN) v = DIM_MIN;
      if (v > DIM_MAX) v = DIM_MAX;
      if (idx == CSR_FRAME_ROWS) begin
         dim_rows = v;
      end else if (idx == CSR_FRAME_COLS) begin
         dim_cols = (v > unsigned'(MAX_COLS_DEFAULT)) ? unsigned'(MAX_COLS_DEFAULT) : v;
      end else begin
         return;
      end
      restart_frame();
   endfunction

   // Takes one accepted word and queues the mean it releases, if any.
   function automatic void take_word(req_word_type w);
      int unsigned total, p, sum, cnt;
      bit up, down, lf, rt;
      rsp_word_type want;
      total = dim_rows * dim_cols;
      if (taken_count < total) begin
         if (w.op == OP_FLUSH) return;
         orig_line[taken_count % WIN_DEPTH] = w.pixel;
      end
      taken_count++;
      if (taken_count < dim_cols + 2) return;

      p = taken_count - dim_cols - 2;
      up = next_row > 0;
      down = next_row + 1 < dim_rows;
      lf = next_col > 0;
      rt = next_col + 1 < dim_cols;
      sum = 0;
      cnt = 0;

      // Upper and left neighbors are already replaced; the others are still original.
      if (up) begin
         if (lf) begin
            sum += 32'(mean_line[(p - dim_cols - 1) % WIN_DEPTH]);
            cnt++;
         end
         sum += 32'(mean_line[(p - dim_cols) % WIN_DEPTH]);
         cnt++;
         if (rt) begin
            sum += 32'(mean_line[(p - dim_cols + 1) % WIN_DEPTH]);
            cnt++;
         end
      end
      if (lf) begin
         sum += 32'(mean_line[(p - 1) % WIN_DEPTH]);
         cnt++;
      end
      if (rt) begin
         sum += 32'(orig_line[(p + 1) % WIN_DEPTH]);
         cnt++;
      end
      if (down) begin
         if (lf) begin
            sum += 32'(orig_line[(p + dim_cols - 1) % WIN_DEPTH]);
            cnt++;
         end
         sum += 32'(orig_line[(p + dim_cols) % WIN_DEPTH]);
         cnt++;
         if (rt) begin
            sum += 32'(orig_line[(p + dim_cols + 1) % WIN_DEPTH]);
            cnt++;
         end
      end

      want.mean_value = PORT_PIXEL_BITS'(sum / cnt);
      mean_line[p % WIN_DEPTH] = want.mean_value;
      want.out_row = OUT_POS_BITS'(next_row);
      want.out_col = OUT_POS_BITS'(next_col);
      want.last_of_frame = (next_row + 1 == dim_rows) && (next_col + 1 == dim_cols);
      expected_means.push_back(want);

      if (want.last_of_frame) begin
         restart_frame();
      end else if (next_col + 1 == dim_cols) begin
         next_col = 0;
         next_row++;
      end else begin
         next_col++;
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // Input driver: a word stays on the port until it is taken.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (!hold && outgoing_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_word <= outgoing_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each accepted input word and checks each accepted result word.
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) take_word(req_word);
         if (rsp_valid && !rsp_stall) begin
            if (expected_means.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected, row %0d col %0d",
                                         rsp_word.out_row, rsp_word.out_col));
            end else begin
               want = expected_means.pop_front();
               check_field("mean_value", 32'(rsp_word.mean_value), 32'(want.mean_value));
               check_field("out_row", 32'(rsp_word.out_row), 32'(want.out_row));
               check_field("out_col", 32'(rsp_word.out_col), 32'(want.out_col));
               check_field("last_of_frame", 32'(rsp_word.last_of_frame),
                           32'(want.last_of_frame));
            end
         end
      end
   end

   function automatic req_word_type make_word(logic op, logic [7:0] px);
      req_word_type w;
      w.op = op;
      w.pixel = px;
      return w;
   endfunction

   // Pixel values lean toward the extremes so that sums reach their limits.
   function automatic logic [7:0] draw_pixel();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(9))
         0: return 2;
         1: return $urandom_range(9, 20);
         default: return $urandom_range(2, 6);
      endcase
   endfunction

   task automatic queue_word(logic op, logic [7:0] px);
      outgoing_words.push_back(make_word(op, px));
   endtask

   // Queues one frame and its drain words. A noisy frame carries ignored flush words
   // and some drain pixels; a cut frame stops partway and is abandoned.
   task automatic queue_frame(input int rows, input int cols, input bit noisy,
                              input bit cut_short, inout int effective);
      int total, stop_at;
      total = rows * cols;
      stop_at = cut_short ? $urandom_range(1, total - 1) : total;
      for (int k = 0; k < stop_at; k++) begin
         if (noisy && $urandom_range(15) == 0) queue_word(OP_FLUSH, draw_pixel());
         queue_word(OP_PIXEL, draw_pixel());
      end
      effective += stop_at;
      if (cut_short) return;
      for (int k = 0; k <= cols; k++) begin
         queue_word((noisy && $urandom_range(3) == 0) ? OP_PIXEL : OP_FLUSH, draw_pixel());
      end
      effective += cols + 1;
      if (noisy) repeat ($urandom_range(2)) queue_word(OP_FLUSH, draw_pixel());
   endtask

   // Waits until every word is taken and every result has come, then lets the pipeline empty.
   task automatic settle();
      do @(negedge clock);
      while (outgoing_words.size() != 0 || req_valid || expected_means.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      apply_csr(idx, data);
   endtask

   // Holds the sender back partway through the queue until all results are in.
   task automatic pause_sender(int keep);
      while (outgoing_words.size() > keep) @(negedge clock);
      @(posedge clock) hold = 1'b1;
      do @(negedge clock);
      while (req_valid || expected_means.size() != 0);
      @(posedge clock) hold = 1'b0;
   endtask

   initial begin : stimulus
      int rows, cols, nframes, phase_no, random_effective, scratch;
      phase_no = 0;
      random_effective = 0;
      scratch = 0;

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset dimensions are 2 x 2. A flush ahead of the frame is ignored, a pixel during
      // the drain acts as a flush, and flush words after the frame end are ignored.
      @(posedge clock);
      queue_word(OP_FLUSH, 8'hA5);
      queue_word(OP_PIXEL, 8'h00);
      queue_word(OP_PIXEL, 8'hFF);
      queue_word(OP_PIXEL, 8'hFF);
      queue_word(OP_PIXEL, 8'h00);
      queue_word(OP_FLUSH, 8'h5A);
      queue_word(OP_PIXEL, 8'hFF);
      queue_word(OP_FLUSH, 8'h00);
      queue_word(OP_FLUSH, 8'hFF);
      settle();

      // Values below the legal range clamp to two; spare indexes leave the frame running.
      write_csr(CSR_FRAME_ROWS, 11'd0);
      write_csr(CSR_FRAME_COLS, 11'd1);
      @(posedge clock);
      queue_word(OP_PIXEL, 8'hFF);
      queue_word(OP_PIXEL, 8'hFF);
      settle();
      write_csr(CSR_SPARE_A, 11'h000);
      write_csr(CSR_SPARE_B, 11'h7FF);
      @(posedge clock);
      queue_word(OP_PIXEL, 8'h80);
      queue_word(OP_PIXEL, 8'h7F);
      repeat (3) queue_word(OP_FLUSH, 8'h00);
      settle();

      // A register write in the middle of a frame restarts it.
      write_csr(CSR_FRAME_COLS, 11'd3);
      @(posedge clock);
      for (int k = 0; k < 5; k++) queue_word(OP_PIXEL, draw_pixel());
      settle();
      write_csr(CSR_FRAME_COLS, 11'd2);
      @(posedge clock);
      queue_frame(2, 2, 1'b0, 1'b0, scratch);
      settle();

      // Largest dimensions: all-ones data clamps to 1024, once per register. The wide
      // frame is cut before its first result and the tall one partway down.
      write_csr(CSR_FRAME_COLS, 11'h7FF);
      @(posedge clock);
      for (int k = 0; k < 48; k++) queue_word(OP_PIXEL, draw_pixel());
      settle();
      write_csr(CSR_FRAME_ROWS, 11'h7FF);
      write_csr(CSR_FRAME_COLS, 11'd2);
      @(posedge clock);
      for (int k = 0; k < 48; k++) queue_word(OP_PIXEL, draw_pixel());
      settle();

      // Random phases: new dimensions, then one to three frames back to back.
      while (random_effective < 720) begin
         phase_no++;
         rows = pick_dim();
         cols = pick_dim();
         if ($urandom_range(1)) begin
            write_csr(CSR_FRAME_ROWS, CSR_DATA_BITS'(rows));
            write_csr(CSR_FRAME_COLS, CSR_DATA_BITS'(cols));
         end else begin
            write_csr(CSR_FRAME_COLS, CSR_DATA_BITS'(cols));
            write_csr(CSR_FRAME_ROWS, CSR_DATA_BITS'(rows));
         end
         @(posedge clock);
         idle_pct = (phase_no >= 6 && phase_no < 12) ? 0 : 28;
         nframes = $urandom_range(1, 3);
         for (int f = 0; f < nframes; f++) begin
            queue_frame(rows, cols, $urandom_range(3) == 0,
                        f == nframes - 1 && $urandom_range(5) == 0, random_effective);
         end
         if (phase_no == 4) pause_sender(outgoing_words.size() / 2);
         settle();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
